### hdl/tcw_pkg.sv
// Shared constants, codes and control types for the text console writer.
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] DEF_ATTR_RST = 8'd15;

  localparam logic [1:0] REQ_PUT_CUR = 2'd0;
  localparam logic [1:0] REQ_PUT_AT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  typedef enum logic [1:0] {
    SW_ZERO,
    SW_CLEAR,
    SW_SCROLL
  } sweep_kind_e;

  typedef struct packed {
    logic        load_req;
    logic        exec_put;
    logic        exec_clear;
    logic        exec_read;
    logic        sweep_start;
    sweep_kind_e sweep_kind;
    logic        sweep_step;
    logic        load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       scroll_need;
    logic       sweep_last;
  } sts_t;

endpackage

### hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tcw_datapath.sv
// Datapath: request registers, cursor, sweep counter, screen memory and result registers.
module tcw_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcw_pkg::cmd_t              cmd_i,
  output tcw_pkg::sts_t              sts_o,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i,
  input  logic [1:0]                 req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0] ch_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute_i,
  input  logic [tcw_pkg::ROW_W-1:0]  row_i,
  input  logic [tcw_pkg::COL_W-1:0]  col_i,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col_o,
  output logic                       scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr_o
);

  logic [tcw_pkg::ATTR_W-1:0] def_attr_q;

  logic [1:0]                 req_q;
  logic [tcw_pkg::CHAR_W-1:0] ch_q;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;

  logic [tcw_pkg::ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [tcw_pkg::COL_W-1:0]  cur_col_q, cur_col_d;
  logic                       scr_q, scr_d;

  logic [tcw_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  tcw_pkg::sweep_kind_e       kind_q, kind_d;
  logic                       sw_vld_q;
  logic [tcw_pkg::ADDR_W-1:0] sw_addr_q;
  logic                       sw_copy_q;
  logic                       sw_copy;

  logic [tcw_pkg::ROW_W-1:0]  tgt_row;
  logic [tcw_pkg::COL_W-1:0]  tgt_col;
  logic [tcw_pkg::ADDR_W-1:0] tgt_addr;
  logic [tcw_pkg::ROW_W:0]    nrow;
  logic [tcw_pkg::COL_W:0]    ncol;
  logic                       is_nl;
  logic                       scroll_need;

  logic                       ram_we;
  logic [tcw_pkg::ADDR_W-1:0] ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [tcw_pkg::CELL_W-1:0] sweep_data;
  logic                       ram_re;
  logic [tcw_pkg::ADDR_W-1:0] ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic [tcw_pkg::ROW_W-1:0]  out_row_q;
  logic [tcw_pkg::COL_W-1:0]  out_col_q;
  logic                       out_scr_q;
  logic [tcw_pkg::CHAR_W-1:0] out_char_q;
  logic [tcw_pkg::ATTR_W-1:0] out_attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= tcw_pkg::DEF_ATTR_RST;
    end else if (cfg_we_i) begin
      def_attr_q <= cfg_wdata_i;
    end
  end

  // Request capture: zero attribute and out-of-range row/column resolved here
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      ch_q   <= ch_i;
      attr_q <= (attribute_i == '0) ? def_attr_q : attribute_i;
      row_q  <= (row_i > tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ?
                tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : row_i;
      col_q  <= (col_i > tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) ?
                tcw_pkg::COL_W'(tcw_pkg::COLS - 1) : col_i;
    end
  end

  assign tgt_row  = (req_q == tcw_pkg::REQ_PUT_CUR) ? cur_row_q : row_q;
  assign tgt_col  = (req_q == tcw_pkg::REQ_PUT_CUR) ? cur_col_q : col_q;
  assign tgt_addr = tcw_pkg::ADDR_W'(tgt_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                    + tcw_pkg::ADDR_W'(tgt_col);
  assign is_nl    = (ch_q == tcw_pkg::NEWLINE_CODE);

  always_comb begin
    if (is_nl) begin
      nrow = {1'b0, tgt_row} + 1'b1;
      ncol = '0;
    end else begin
      ncol = {1'b0, tgt_col} + 1'b1;
      if (ncol == (tcw_pkg::COL_W+1)'(tcw_pkg::COLS)) begin
        ncol = '0;
        nrow = {1'b0, tgt_row} + 1'b1;
      end else begin
        nrow = {1'b0, tgt_row};
      end
    end
  end

  assign scroll_need = (nrow == (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    scr_d     = scr_q;
    if (cmd_i.exec_put) begin
      cur_row_d = scroll_need ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : nrow[tcw_pkg::ROW_W-1:0];
      cur_col_d = ncol[tcw_pkg::COL_W-1:0];
      scr_d     = scroll_need;
    end else if (cmd_i.exec_clear) begin
      cur_row_d = '0;
      cur_col_d = '0;
      scr_d     = 1'b0;
    end else if (cmd_i.exec_read) begin
      scr_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
      scr_q     <= 1'b0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      scr_q     <= scr_d;
    end
  end

  // Sweep: for a scroll the issue stage reads the source row; the write stage lands in the cycle after
  assign sw_copy = (kind_q == tcw_pkg::SW_SCROLL) &&
                   (cnt_q < tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS));

  always_comb begin
    cnt_d  = cnt_q;
    kind_d = kind_q;
    if (cmd_i.sweep_start) begin
      cnt_d  = '0;
      kind_d = cmd_i.sweep_kind;
    end else if (cmd_i.sweep_step) begin
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      kind_q   <= tcw_pkg::SW_ZERO;
      sw_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      kind_q   <= kind_d;
      sw_vld_q <= cmd_i.sweep_step;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_addr_q <= cnt_q;
    sw_copy_q <= sw_copy;
  end

  always_comb begin
    case (kind_q)
      tcw_pkg::SW_SCROLL: sweep_data = sw_copy_q ? ram_rdata : '0;
      tcw_pkg::SW_CLEAR:  sweep_data = {def_attr_q, tcw_pkg::SPACE_CODE};
      default:            sweep_data = '0;
    endcase
  end

  assign ram_we    = sw_vld_q || (cmd_i.exec_put && !is_nl);
  assign ram_waddr = sw_vld_q ? sw_addr_q : tgt_addr;
  assign ram_wdata = sw_vld_q ? sweep_data : {attr_q, ch_q};
  assign ram_re    = cmd_i.exec_read || (cmd_i.sweep_step && sw_copy);
  assign ram_raddr = cmd_i.exec_read ? tgt_addr :
                     (cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLS));

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q <= cur_row_q;
      out_col_q <= cur_col_q;
      out_scr_q <= scr_q;
      if (req_q == tcw_pkg::REQ_READ) begin
        out_char_q <= ram_rdata[tcw_pkg::CHAR_W-1:0];
        out_attr_q <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end else begin
        out_char_q <= '0;
        out_attr_q <= '0;
      end
    end
  end

  assign sts_o.req_type    = req_q;
  assign sts_o.scroll_need = scroll_need;
  assign sts_o.sweep_last  = (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));

  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;
  assign cell_char_o  = out_char_q;
  assign cell_attr_o  = out_attr_q;

endmodule

### hdl/tcw_ctrl.sv
// Controller: sequences requests, memory sweeps and the result beat.
module tcw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tcw_pkg::sts_t sts_i,
  output tcw_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       init_q, init_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    cmd_o   = '0;
    cmd_o.sweep_kind = tcw_pkg::SW_ZERO;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.req_type inside {tcw_pkg::REQ_PUT_CUR, tcw_pkg::REQ_PUT_AT}) begin
          cmd_o.exec_put = 1'b1;
          if (sts_i.scroll_need) begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = tcw_pkg::SW_SCROLL;
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_DONE;
          end
        end else if (sts_i.req_type == tcw_pkg::REQ_CLEAR) begin
          cmd_o.exec_clear  = 1'b1;
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_kind  = tcw_pkg::SW_CLEAR;
          state_d = ST_SWEEP;
        end else begin
          cmd_o.exec_read = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last sweep write lands this cycle
        if (init_q) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || cmd_o.load_out;

  // Reset starts with a zero-fill sweep of the screen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/text_console_writer.sv
// Text console writer: character/attribute screen store with cursor, scroll and clear.
// Sequence: a put or read is captured, executed and then loaded as its result beat; a put
// that scrolls, or a clear, also sweeps the screen memory one cell per cycle, then drains.
// Throughput: one item in flight; the next beat is taken once the result is registered,
// even while that result waits at the output.
// Reset: a zero-fill pass over all 2000 cells, with input stalled.
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0] ch_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attribute_i,
  input  logic [tcw_pkg::ROW_W-1:0]  row_i,
  input  logic [tcw_pkg::COL_W-1:0]  col_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col_o,
  output logic                       scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr_o
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcw_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .ch_i         (ch_i),
    .attribute_i  (attribute_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous beat still in progress");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_row_o <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) &&
                    (cursor_col_o <= tcw_pkg::COL_W'(tcw_pkg::COLS - 1)))
    else $error("cursor outside screen");

  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scrolled_o) |->
      (cursor_row_o == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) && (cursor_col_o == '0))
    else $error("scroll left cursor off start of bottom row");

endmodule
